@@ src/assert_macros.svh @@
// assertion macros shared by the stack machine sources
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define ISM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define ISM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ism_pkg.sv @@
// shared types, sizes and codes for the integer stack machine
// no dependencies; used by every other source file except assert_macros.svh
package ism_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 3;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [KIND_W-1:0]        kind_type;
   typedef logic [STATUS_W-1:0]      status_type;

   // request opcodes as they arrive
   localparam kind_type KIND_PUSH = 3'd0;
   localparam kind_type KIND_DUMP = 3'd1;
   localparam kind_type KIND_PEEK = 3'd2;
   localparam kind_type KIND_POP  = 3'd3;
   localparam kind_type KIND_ADD  = 3'd4;

   // status codes
   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_PEEK_EMPTY = 3'd1;
   localparam status_type ST_POP_EMPTY  = 3'd2;
   localparam status_type ST_ADD_SHORT  = 3'd3;
   localparam status_type ST_PUSH_FULL  = 3'd4;

   // decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_DUMP,
      OP_ADD
   } op_type;

   typedef struct packed {
      op_type   op;
      word_type value;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      word_type   value;
      logic       has_value;
      status_type status;
      logic       last;
   } rsp_type;

endpackage

@@ src/ism_chan_if.sv @@
// request and response channel interfaces of the stack machine
// depends on ism_pkg
interface ism_req_if;
   logic               valid;
   logic               ready;
   ism_pkg::kind_type  kind;
   ism_pkg::word_type  push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface ism_rsp_if;
   logic                valid;
   logic                ready;
   ism_pkg::word_type   value;
   logic                has_value;
   ism_pkg::status_type status;
   logic                last;

   modport source (output valid, output value, output has_value, output status,
                   output last, input ready);
   modport sink   (input valid, input value, input has_value, input status,
                   input last, output ready);
endinterface

@@ src/ism_front.sv @@
// front end: accepts requests and decodes the opcode into an operation
// depends on ism_pkg and ism_chan_if
module ism_front (
   ism_req_if.sink           req_bus,
   output ism_pkg::cmd_type  cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import ism_pkg::*;

   op_type op;

   // opcode decode, unknown kinds become a no-op
   always_comb begin
      unique case (req_bus.kind)
         KIND_PUSH: op = OP_PUSH;
         KIND_DUMP: op = OP_DUMP;
         KIND_PEEK: op = OP_PEEK;
         KIND_POP:  op = OP_POP;
         KIND_ADD:  op = OP_ADD;
         default:   op = OP_NOP;
      endcase
   end

   // only a push carries its value forward
   assign cmd.op        = op;
   assign cmd.value     = (op == OP_PUSH) ? req_bus.push_value : '0;
   assign cmd_valid     = req_bus.valid;
   assign req_bus.ready = cmd_ready;

endmodule

@@ src/ism_queue.sv @@
// two-entry command queue between front and back
// depends on ism_pkg
module ism_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ism_pkg::cmd_type       in_cmd,
   input  logic                   in_valid,
   output logic                   in_ready,
   output ism_pkg::cmd_type       out_cmd,
   output logic                   out_valid,
   input  logic                   out_pop,
   output ism_pkg::q_status_type  status
);
   import ism_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready     = (count_ff != 2'd2);
   assign out_valid    = (count_ff != 2'd0);
   assign out_cmd      = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

   assign push = in_valid && in_ready;
   assign pop  = out_pop && out_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

@@ src/ism_back.sv @@
// back end: stack memory, entry count, operation sequencer, response register
// depends on ism_pkg and ism_chan_if
module ism_back (
   input  logic              clock,
   input  logic              reset,
   input  ism_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   ism_rsp_if.source         rsp_bus
);
   import ism_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DUMP = 2'd1;
   localparam logic [1:0] S_ADD  = 2'd2;

   word_type            mem [STACK_DEPTH];
   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                peek_ff, peek_in;
   word_type            rd_a_ff, rd_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                out_free;
   logic [CNT_W-1:0]    cnt_m1, cnt_m2;
   logic                is_empty, is_full, is_short;
   logic                emit;
   rsp_type             emit_rsp;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   word_type            wr_data;
   logic                rd_a_en, rd_b_en;
   logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_m2   = count_ff - CNT_W'(2);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_short = (count_ff < CNT_W'(2));

   // operation sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      peek_in   = peek_ff;
      cmd_pop   = 1'b0;
      emit      = 1'b0;
      emit_rsp  = '{value: '0, has_value: 1'b0, status: ST_OK, last: 1'b1};
      wr_en     = 1'b0;
      wr_addr   = count_ff[ADDR_W-1:0];
      wr_data   = cmd.value;
      rd_a_en   = 1'b0;
      rd_a_addr = cnt_m1[ADDR_W-1:0];
      rd_b_en   = 1'b0;
      rd_b_addr = cnt_m2[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_PUSH: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        if (is_full) begin
                           emit_rsp.status = ST_PUSH_FULL;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_POP: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        if (is_empty) begin
                           emit_rsp.status = ST_POP_EMPTY;
                        end else begin
                           count_in = cnt_m1;
                        end
                     end
                  end
                  OP_PEEK, OP_DUMP: begin
                     if (is_empty) begin
                        if (out_free) begin
                           cmd_pop = 1'b1;
                           emit    = 1'b1;
                           emit_rsp.status = (cmd.op == OP_PEEK) ? ST_PEEK_EMPTY : ST_OK;
                        end
                     end else begin
                        // fetch the top entry, results leave from the dump state
                        cmd_pop  = 1'b1;
                        rd_a_en  = 1'b1;
                        idx_in   = cnt_m1[ADDR_W-1:0];
                        peek_in  = (cmd.op == OP_PEEK);
                        state_in = S_DUMP;
                     end
                  end
                  OP_ADD: begin
                     if (is_short) begin
                        if (out_free) begin
                           cmd_pop = 1'b1;
                           emit    = 1'b1;
                           emit_rsp.status = ST_ADD_SHORT;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        rd_a_en  = 1'b1;
                        rd_b_en  = 1'b1;
                        state_in = S_ADD;
                     end
                  end
                  OP_NOP: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_DUMP: begin
            // one entry per cycle while the response register is free, next read overlaps the current result
            if (out_free) begin
               emit               = 1'b1;
               emit_rsp.value     = rd_a_ff;
               emit_rsp.has_value = 1'b1;
               emit_rsp.last      = peek_ff || (idx_ff == '0);
               if (emit_rsp.last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_a_en   = 1'b1;
                  rd_a_addr = idx_ff - ADDR_W'(1);
                  idx_in    = idx_ff - ADDR_W'(1);
               end
            end
         end
         S_ADD: begin
            // second entry takes the wrapped sum, top is dropped
            if (out_free) begin
               emit     = 1'b1;
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[ADDR_W-1:0];
               wr_data  = rd_b_ff + rd_a_ff;
               count_in = cnt_m1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = emit_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      peek_ff <= peek_in;
      rsp_ff  <= rsp_in;
   end

   // stack memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.value     = rsp_ff.value;
   assign rsp_bus.has_value = rsp_ff.has_value;
   assign rsp_bus.status    = rsp_ff.status;
   assign rsp_bus.last      = rsp_ff.last;

endmodule

@@ src/integer_stack_machine_top.sv @@
// Integer stack machine: a bounded LIFO of signed 32-bit words.
// req_bus carries one request per handshake (kind, push_value); rsp_bus
// returns the results, each with value, has_value, status and last.
// Push, pop and unknown kinds give one result, through the queue and the
// response register, and retire one per cycle. Peek and add on a stack with
// enough entries give one result via the dump or add state: add reads both
// top entries from the stack memory, then writes their sum; their empty or
// short errors skip that state. A dump gives one result per stored entry
// (one without value if empty), top first, one per cycle after a registered
// memory read; last marks the final result of each request. Errors report
// a status code and leave the stack unchanged. A two-entry queue sits
// between the decode front and the execution back, so requests keep arriving
// while a result waits. When the receiver stalls, the response register
// holds, the back end stops, and the queue fills before req_bus.ready falls.
// Reset (synchronous) empties the stack and the queue; no clearing pass is
// needed because stack words are only read below the entry count.
// depends on ism_pkg, ism_chan_if, ism_front, ism_queue, ism_back, assert_macros.svh
`include "assert_macros.svh"

module integer_stack_machine_top (
   input  logic      clock,
   input  logic      reset,
   ism_req_if.sink   req_bus,
   ism_rsp_if.source rsp_bus
);
   import ism_pkg::*;

   cmd_type       front_cmd;
   logic          front_valid;
   logic          front_ready;
   cmd_type       back_cmd;
   logic          back_valid;
   logic          back_pop;
   q_status_type  q_stat;

   // decode
   ism_front u_front (
      .req_bus   (req_bus),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   // decoupling queue
   ism_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (back_cmd),
      .out_valid (back_valid),
      .out_pop   (back_pop),
      .status    (q_stat)
   );

   // execution
   ism_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_pop   (back_pop),
      .rsp_bus   (rsp_bus)
   );

   // checks
   `ISM_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock,
      reset |=> !rsp_bus.valid, "response valid after reset")
   `ISM_ASSERT(a_value_only_ok, clock, reset,
      rsp_bus.valid |-> (!rsp_bus.has_value || rsp_bus.status == ST_OK),
      "value with error status")
   `ISM_ASSERT(a_mid_dump_has_value, clock, reset,
      (rsp_bus.valid && !rsp_bus.last) |-> rsp_bus.has_value,
      "non-final result without value")
   `ISM_ASSERT(a_queue_full_blocks, clock, reset,
      q_stat.full |-> !req_bus.ready, "request taken while queue full")

endmodule
